// ----- hdl/gdqo_pkg.sv -----
// gdqo_pkg: shared types, constants and the encoder step table of the dual odometer
// no dependencies
package gdqo_pkg;

	localparam int ACCUM_BITS_DEFAULT = 32;
	localparam int CFG_BITS = 31;
	localparam int FIFO_DEPTH = 3;

	localparam logic [CFG_BITS-1:0] SPEED_THRESHOLD_RESET = 31'd1000;
	localparam logic [CFG_BITS-1:0] TILT_LIMIT_RESET = 31'd450000;

	localparam logic [1:0] MASK_PIN0 = 2'b01;
	localparam logic [1:0] MASK_PIN1 = 2'b10;
	localparam logic [1:0] MASK_BOTH = 2'b11;

	localparam logic signed [1:0] MID_FWD = 2'sd1;
	localparam logic signed [1:0] MID_REV = -2'sd1;
	localparam logic signed [1:0] MID_NONE = 2'sd0;

	typedef enum logic [0:0] {
		REG_SPEED_THRESHOLD = 1'b0,
		REG_TILT_LIMIT = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic command;
		logic [1:0] right_pins;
		logic [1:0] left_pins;
		logic signed [31:0] speed_right;
		logic signed [31:0] speed_left;
		logic signed [31:0] angle_fused;
	} sample_t;

	typedef struct packed {
		logic signed [15:0] right_count;
		logic signed [15:0] left_count;
		logic signed [31:0] travel;
		logic signed [31:0] side_difference;
	} result_t;

	typedef struct packed {
		logic valid;
		logic clear;
		logic signed [15:0] right_count;
		logic signed [15:0] left_count;
	} tick_t;

	// step tables, rows for last pins 0 and 3, indexed by new pins
	localparam logic signed [2:0] RIGHT_ROW0 [4] = '{3'sd0, 3'sd0, -3'sd1, 3'sd0};
	localparam logic signed [2:0] RIGHT_ROW3 [4] = '{3'sd0, -3'sd1, 3'sd2, 3'sd0};
	localparam logic signed [2:0] LEFT_ROW0 [4] = '{3'sd0, -3'sd1, 3'sd1, 3'sd0};
	localparam logic signed [2:0] LEFT_ROW3 [4] = '{3'sd0, 3'sd1, -3'sd1, 3'sd0};

	function automatic logic signed [2:0] step_lookup(input logic right, input logic [1:0] from,
			input logic [1:0] to, input logic signed [1:0] mid);
		logic signed [2:0] step;
		step = 3'sd0;
		if ((from == 2'd1 && to == 2'd2) || (from == 2'd2 && to == 2'd1)) begin
			step = 3'(mid);
		end else if (from == 2'd0) begin
			step = right ? RIGHT_ROW0[to] : LEFT_ROW0[to];
		end else if (from == 2'd3) begin
			step = right ? RIGHT_ROW3[to] : LEFT_ROW3[to];
		end
		return step;
	endfunction

endpackage

// ----- hdl/gated_dual_quadrature_odometer_unit.sv -----
// an accepted tick is registered in tick_s1, then its result is queued
// throughput: one sample per cycle unless stalled, set by the lane state update
// a three-entry result queue lets samples flow while results wait, until full
// reset: asynchronous, active low; counts, accumulators and queue cleared,
// pin masks open on both pins, registers to their default values
module gated_dual_quadrature_odometer_unit import gdqo_pkg::*; #(
	parameter int ACCUM_BITS = ACCUM_BITS_DEFAULT
) (
	input  logic clk,
	input  logic arst_n,
	input  logic sample_valid,
	output logic sample_stall,
	input  sample_t sample,
	output logic result_valid,
	input  logic result_stall,
	output result_t result,
	input  logic cfg_we,
	input  cfg_reg_t cfg_index,
	input  logic [CFG_BITS-1:0] cfg_data
);

	logic [CFG_BITS-1:0] threshold_q;
	logic [CFG_BITS-1:0] tilt_limit_q;
	tick_t tick_s1;

	logic accept;
	logic tick;
	logic tilt_over;
	logic signed [15:0] right_count;
	logic signed [15:0] left_count;

	always_comb begin
		accept = sample_valid && !sample_stall;
		tick = sample.command;
		tilt_over = ($signed({sample.angle_fused[31], sample.angle_fused})
				> $signed({2'b00, tilt_limit_q}))
			|| ($signed({sample.angle_fused[31], sample.angle_fused})
				< -$signed({2'b00, tilt_limit_q}));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= SPEED_THRESHOLD_RESET;
			tilt_limit_q <= TILT_LIMIT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SPEED_THRESHOLD: threshold_q <= cfg_data;
				REG_TILT_LIMIT: tilt_limit_q <= cfg_data;
				default: ;
			endcase
		end
	end

	gdqo_lane u_lane_right (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.tick(tick),
		.lane_right(1'b1),
		.pins(sample.right_pins),
		.speed(sample.speed_right),
		.threshold(threshold_q),
		.count(right_count)
	);

	gdqo_lane u_lane_left (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.tick(tick),
		.lane_right(1'b0),
		.pins(sample.left_pins),
		.speed(sample.speed_left),
		.threshold(threshold_q),
		.count(left_count)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_s1 <= '0;
		end else begin
			tick_s1.valid <= accept && tick;
			tick_s1.clear <= tilt_over;
			tick_s1.right_count <= right_count;
			tick_s1.left_count <= left_count;
		end
	end

	gdqo_merge #(
		.ACCUM_BITS(ACCUM_BITS)
	) u_merge (
		.clk(clk),
		.arst_n(arst_n),
		.tick_s1(tick_s1),
		.busy(sample_stall),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

`ifndef SYNTH
	// an accepted tick transaction reaches the merge stage next cycle
	a_tick_reaches_merge: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && !sample_stall && sample.command |=> tick_s1.valid)
		else $error("accepted tick did not reach merge stage");

	// the input side only stalls while results are queued
	a_stall_needs_results: assert property (@(posedge clk) disable iff (!arst_n)
		sample_stall |-> result_valid)
		else $error("input stalled with no pending result");

	// a plain sample never produces a merge entry
	a_no_spurious_tick: assert property (@(posedge clk) disable iff (!arst_n)
		!(sample_valid && !sample_stall && sample.command) |=> !tick_s1.valid)
		else $error("merge entry without accepted tick");
`endif

endmodule

// ----- hdl/gdqo_lane.sv -----
// gdqo_lane: one wheel's quadrature decoder with pin gating and tick-time mask choice
// depends on gdqo_pkg
module gdqo_lane import gdqo_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic accept,
	input  logic tick,
	input  logic lane_right,
	input  logic [1:0] pins,
	input  logic signed [31:0] speed,
	input  logic [CFG_BITS-1:0] threshold,
	output logic signed [15:0] count
);

	logic [1:0] last_q;
	logic signed [15:0] steps_q;
	logic [1:0] mask_q;
	logic signed [1:0] mid_q;

	logic changed;
	logic signed [2:0] step;
	logic signed [15:0] steps_new;
	logic fast_fwd;
	logic fast_rev;
	logic [1:0] mask_next;
	logic signed [1:0] mid_next;

	always_comb begin
		changed = ((pins ^ last_q) & mask_q) != 2'b00;
		step = step_lookup(lane_right, last_q, pins, mid_q);
		steps_new = changed ? steps_q + 16'(step) : steps_q;
		count = steps_new;
		fast_fwd = $signed({speed[31], speed}) > $signed({2'b00, threshold});
		fast_rev = $signed({speed[31], speed}) < -$signed({2'b00, threshold});
		priority if (fast_fwd) begin
			mask_next = lane_right ? MASK_PIN0 : MASK_PIN1;
			mid_next = MID_FWD;
		end else if (fast_rev) begin
			mask_next = lane_right ? MASK_PIN1 : MASK_PIN0;
			mid_next = MID_REV;
		end else begin
			mask_next = MASK_BOTH;
			mid_next = MID_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= 2'b00;
			steps_q <= '0;
			mask_q <= MASK_BOTH;
			mid_q <= MID_NONE;
		end else if (accept) begin
			if (changed) begin
				last_q <= pins;
			end
			steps_q <= tick ? 16'sd0 : steps_new;
			if (tick) begin
				mask_q <= mask_next;
				mid_q <= mid_next;
			end
		end
	end

endmodule

// ----- hdl/gdqo_merge.sv -----
// gdqo_merge: combines both lane counts into travel and side accumulators, queues results
// depends on gdqo_pkg
module gdqo_merge import gdqo_pkg::*; #(
	parameter int ACCUM_BITS = ACCUM_BITS_DEFAULT
) (
	input  logic clk,
	input  logic arst_n,
	input  tick_t tick_s1,
	output logic busy,
	output logic result_valid,
	input  logic result_stall,
	output result_t result
);

	logic signed [ACCUM_BITS-1:0] travel_q;
	logic signed [ACCUM_BITS-1:0] side_q;
	result_t fifo_q [FIFO_DEPTH];
	logic [1:0] wr_ptr_q;
	logic [1:0] rd_ptr_q;
	logic [1:0] count_q;

	logic signed [16:0] pair_sum;
	logic signed [16:0] pair_diff;
	logic signed [ACCUM_BITS-1:0] travel_next;
	logic signed [ACCUM_BITS-1:0] side_next;
	logic push;
	logic pop;
	result_t entry;

	always_comb begin
		pair_sum = 17'(tick_s1.right_count) + 17'(tick_s1.left_count);
		pair_diff = 17'(tick_s1.right_count) - 17'(tick_s1.left_count);
		travel_next = tick_s1.clear ? '0 : travel_q + ACCUM_BITS'(pair_sum);
		side_next = tick_s1.clear ? '0 : side_q + ACCUM_BITS'(pair_diff);
		entry.right_count = tick_s1.right_count;
		entry.left_count = tick_s1.left_count;
		entry.travel = 32'(travel_next);
		entry.side_difference = 32'(side_next);
		push = tick_s1.valid;
		result_valid = count_q != 2'd0;
		pop = result_valid && !result_stall;
		result = fifo_q[rd_ptr_q];
		busy = ({1'b0, count_q} + {2'b00, tick_s1.valid}) >= 3'(FIFO_DEPTH);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			travel_q <= '0;
			side_q <= '0;
			wr_ptr_q <= 2'd0;
			rd_ptr_q <= 2'd0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				travel_q <= travel_next;
				side_q <= side_next;
				wr_ptr_q <= (wr_ptr_q == 2'(FIFO_DEPTH - 1)) ? 2'd0 : wr_ptr_q + 2'd1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == 2'(FIFO_DEPTH - 1)) ? 2'd0 : rd_ptr_q + 2'd1;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= entry;
		end
	end

endmodule

// ----- test/tb.sv -----
// tb: self-checking testbench for gated_dual_quadrature_odometer_unit
// depends on gdqo_pkg and the odometer unit; a directed table, then random phases
// each tick transaction is predicted in-bench and compared field by field
`timescale 1ns / 100ps

module tb;
	import gdqo_pkg::*;

	localparam logic signed [31:0] S32_MAX = 32'sh7fffffff;
	localparam logic signed [31:0] S32_MIN = 32'sh80000000;
	localparam logic [CFG_BITS-1:0] CFG_MAX = '1;

	typedef struct {
		logic typed;
		sample_t s;
		result_t want;
	} directed_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic sample_valid = 1'b0;
	logic sample_stall;
	sample_t sample = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	result_t result;
	logic cfg_we = 1'b0;
	cfg_reg_t cfg_index = REG_SPEED_THRESHOLD;
	logic [CFG_BITS-1:0] cfg_data = '0;

	// predictor state
	logic [CFG_BITS-1:0] speed_thr = SPEED_THRESHOLD_RESET;
	logic [CFG_BITS-1:0] tilt_lim = TILT_LIMIT_RESET;
	logic [1:0] r_last = 2'd0, l_last = 2'd0;
	logic signed [15:0] r_steps = '0, l_steps = '0;
	logic [1:0] r_mask = MASK_BOTH, l_mask = MASK_BOTH;
	int r_mid = 0, l_mid = 0;
	logic signed [31:0] travel_acc = '0, side_acc = '0;

	result_t expected_odometry [$];
	int mismatch_count = 0;
	bit idling_on = 1'b1;
	int stall_left = 0;

	directed_row_t directed_rows [] = '{
		'{1'b1, '{1'b1, 2'd0, 2'd0, 32'sd0, 32'sd0, 32'sd0}, '0},
		'{1'b0, '{1'b0, 2'd2, 2'd1, 32'sd0, 32'sd0, 32'sd0}, '0},
		'{1'b0, '{1'b0, 2'd3, 2'd3, 32'sd0, 32'sd0, 32'sd0}, '0},
		'{1'b0, '{1'b0, 2'd1, 2'd2, 32'sd0, 32'sd0, 32'sd0}, '0},
		'{1'b0, '{1'b0, 2'd2, 2'd1, 32'sd0, 32'sd0, 32'sd0}, '0},
		'{1'b0, '{1'b1, 2'd3, 2'd0, S32_MAX, S32_MIN, 32'sd0}, '0},
		'{1'b0, '{1'b0, 2'd2, 2'd2, 32'sd0, 32'sd0, 32'sd0}, '0},
		'{1'b0, '{1'b0, 2'd1, 2'd1, 32'sd0, 32'sd0, 32'sd0}, '0},
		'{1'b0, '{1'b0, 2'd0, 2'd3, 32'sd0, 32'sd0, 32'sd0}, '0},
		'{1'b0, '{1'b1, 2'd0, 2'd1, 32'sd1000, -32'sd1000, 32'sd450000}, '0},
		'{1'b1, '{1'b1, 2'd0, 2'd1, 32'sd1001, -32'sd1001, 32'sd450001}, '0},
		'{1'b0, '{1'b0, 2'd2, 2'd0, 32'sd0, 32'sd0, 32'sd0}, '0},
		'{1'b0, '{1'b0, 2'd1, 2'd2, 32'sd0, 32'sd0, 32'sd0}, '0},
		'{1'b0, '{1'b0, 2'd2, 2'd1, 32'sd0, 32'sd0, 32'sd0}, '0},
		'{1'b0, '{1'b1, 2'd3, 2'd3, -32'sd1001, 32'sd1001, -32'sd450001}, '0},
		'{1'b0, '{1'b0, 2'd1, 2'd2, 32'sd0, 32'sd0, 32'sd0}, '0},
		'{1'b0, '{1'b0, 2'd2, 2'd1, 32'sd0, 32'sd0, 32'sd0}, '0},
		'{1'b0, '{1'b1, 2'd2, 2'd1, 32'sd0, 32'sd0, S32_MIN}, '0},
		'{1'b1, '{1'b1, 2'd2, 2'd1, 32'sd0, 32'sd0, S32_MAX}, '0},
		'{1'b0, '{1'b0, 2'd3, 2'd0, 32'sd0, 32'sd0, 32'sd0}, '0},
		'{1'b0, '{1'b0, 2'd0, 2'd3, 32'sd0, 32'sd0, 32'sd0}, '0},
		'{1'b0, '{1'b0, 2'd1, 2'd2, 32'sd0, 32'sd0, 32'sd0}, '0},
		'{1'b0, '{1'b1, 2'd3, 2'd0, 32'sd12345, -32'sd54321, -32'sd450000}, '0}
	};

	gated_dual_quadrature_odometer_unit u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.sample(sample),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	// signed step for one wheel, from the last accepted pins to the new pins
	function automatic int encoder_step(input bit right, input logic [1:0] from,
			input logic [1:0] to, input int mid);
		int step;
		step = 0;
		if ((from == 2'd1 && to == 2'd2) || (from == 2'd2 && to == 2'd1)) begin
			step = mid;
		end else if (from == 2'd0) begin
			case (to)
				2'd1: step = right ? 0 : -1;
				2'd2: step = right ? -1 : 1;
				default: step = 0;
			endcase
		end else if (from == 2'd3) begin
			case (to)
				2'd1: step = right ? -1 : 1;
				2'd2: step = right ? 2 : -1;
				default: step = 0;
			endcase
		end
		return step;
	endfunction

	task automatic advance_odometer(input sample_t s);
		longint thr, lim, ang;
		logic signed [15:0] rc, lc;
		result_t r;
		thr = longint'(speed_thr);
		lim = longint'(tilt_lim);
		ang = longint'(s.angle_fused);
		if (((s.right_pins ^ r_last) & r_mask) != 2'b00) begin
			r_steps = r_steps + 16'(encoder_step(1'b1, r_last, s.right_pins, r_mid));
			r_last = s.right_pins;
		end
		if (((s.left_pins ^ l_last) & l_mask) != 2'b00) begin
			l_steps = l_steps + 16'(encoder_step(1'b0, l_last, s.left_pins, l_mid));
			l_last = s.left_pins;
		end
		if (!s.command) return;
		if (longint'(s.speed_right) > thr) begin
			r_mask = MASK_PIN0;
			r_mid = 1;
		end else if (longint'(s.speed_right) < -thr) begin
			r_mask = MASK_PIN1;
			r_mid = -1;
		end else begin
			r_mask = MASK_BOTH;
			r_mid = 0;
		end
		if (longint'(s.speed_left) > thr) begin
			l_mask = MASK_PIN1;
			l_mid = 1;
		end else if (longint'(s.speed_left) < -thr) begin
			l_mask = MASK_PIN0;
			l_mid = -1;
		end else begin
			l_mask = MASK_BOTH;
			l_mid = 0;
		end
		rc = r_steps;
		lc = l_steps;
		r_steps = '0;
		l_steps = '0;
		travel_acc = travel_acc + 32'(rc) + 32'(lc);
		side_acc = side_acc + 32'(rc) - 32'(lc);
		if (ang > lim || ang < -lim) begin
			travel_acc = '0;
			side_acc = '0;
		end
		r.right_count = rc;
		r.left_count = lc;
		r.travel = travel_acc;
		r.side_difference = side_acc;
		expected_odometry.push_back(r);
	endtask

	task automatic send_item(input sample_t s);
		int gap;
		gap = 0;
		if (idling_on && $urandom_range(0, 7) == 0) gap = $urandom_range(1, 15);
		if (gap > 0) begin
			sample_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		sample_valid <= 1'b1;
		sample <= s;
		do @(posedge clk); while (sample_stall);
		advance_odometer(s);
		@(negedge clk);
	endtask

	task automatic drain(input int settle);
		sample_valid <= 1'b0;
		while (expected_odometry.size() != 0) @(negedge clk);
		repeat (settle) @(negedge clk);
	endtask

	task automatic cfg_write(input cfg_reg_t idx, input logic [CFG_BITS-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_SPEED_THRESHOLD) speed_thr = val;
		else tilt_lim = val;
	endtask

	// values clustered around a limit, plus full-range, extreme and near-zero values
	function automatic logic [31:0] near_limit(input longint lim);
		longint v;
		case ($urandom_range(0, 4))
			0: v = longint'($urandom);
			1: v = lim + longint'($urandom_range(0, 4)) - 2;
			2: v = -lim + longint'($urandom_range(0, 4)) - 2;
			3: v = $urandom_range(0, 1) ? longint'(S32_MAX) : longint'(S32_MIN);
			default: v = longint'($urandom_range(0, 40)) - 20;
		endcase
		return v[31:0];
	endfunction

	// mostly legal quadrature moves in the wheel's direction, some holds and jumps
	function automatic logic [1:0] next_pins(input logic [1:0] cur, input bit fwd);
		int m;
		logic [1:0] nxt;
		m = $urandom_range(0, 9);
		if (m >= 8) return 2'($urandom_range(0, 3));
		if (m == 7) return cur;
		case (cur)
			2'd0: nxt = fwd ? 2'd1 : 2'd2;
			2'd1: nxt = fwd ? 2'd3 : 2'd0;
			2'd3: nxt = fwd ? 2'd2 : 2'd1;
			default: nxt = fwd ? 2'd0 : 2'd3;
		endcase
		return nxt;
	endfunction

	always @(negedge clk) begin
		if (!idling_on) begin
			result_stall <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			result_stall <= 1'b1;
		end else if ($urandom_range(0, 7) == 0) begin
			stall_left <= $urandom_range(0, 14);
			result_stall <= 1'b1;
		end else begin
			result_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (expected_odometry.size() == 0) begin
				$error("unexpected result transaction");
				mismatch_count++;
			end else begin
				want = expected_odometry.pop_front();
				if (result.right_count !== want.right_count) begin
					$error("right_count expected %0d got %0d", want.right_count,
						result.right_count);
					mismatch_count++;
				end
				if (result.left_count !== want.left_count) begin
					$error("left_count expected %0d got %0d", want.left_count,
						result.left_count);
					mismatch_count++;
				end
				if (result.travel !== want.travel) begin
					$error("travel expected %0d got %0d", want.travel, result.travel);
					mismatch_count++;
				end
				if (result.side_difference !== want.side_difference) begin
					$error("side_difference expected %0d got %0d", want.side_difference,
						result.side_difference);
					mismatch_count++;
				end
			end
		end
	end

	initial begin
		#20_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		sample_t s;
		logic [CFG_BITS-1:0] thr, lim;
		logic [1:0] rp, lp;
		bit r_fwd, l_fwd;
		int n_items;
		rp = 2'd0;
		lp = 2'd0;
		r_fwd = 1'b1;
		l_fwd = 1'b0;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_rows[i]) begin
			send_item(directed_rows[i].s);
			if (directed_rows[i].typed) expected_odometry[$] = directed_rows[i].want;
		end

		for (int p = 0; p < 6; p++) begin
			case (p)
				0: begin
					thr = '0;
					lim = '0;
					n_items = 250;
					idling_on = 1'b1;
				end
				1: begin
					thr = CFG_MAX;
					lim = CFG_MAX;
					n_items = 250;
					idling_on = 1'b1;
				end
				2: begin
					thr = CFG_BITS'($urandom_range(0, 5000));
					lim = CFG_BITS'($urandom_range(0, 1000000));
					n_items = 300;
					idling_on = 1'b0;
				end
				3: begin
					thr = SPEED_THRESHOLD_RESET;
					lim = TILT_LIMIT_RESET;
					n_items = 300;
					idling_on = 1'b1;
				end
				4: begin
					thr = CFG_BITS'($urandom);
					lim = CFG_BITS'($urandom);
					n_items = 300;
					idling_on = 1'b1;
				end
				default: begin
					thr = CFG_BITS'($urandom_range(0, 200));
					lim = CFG_BITS'($urandom_range(0, 100000));
					n_items = 250;
					idling_on = 1'b0;
				end
			endcase
			drain(4);
			cfg_write(REG_SPEED_THRESHOLD, thr);
			cfg_write(REG_TILT_LIMIT, lim);
			@(negedge clk);
			for (int i = 0; i < n_items; i++) begin
				if ($urandom_range(0, 15) == 0) r_fwd = ~r_fwd;
				if ($urandom_range(0, 15) == 0) l_fwd = ~l_fwd;
				rp = next_pins(rp, r_fwd);
				lp = next_pins(lp, l_fwd);
				s.command = ($urandom_range(0, 5) == 0);
				s.right_pins = rp;
				s.left_pins = lp;
				s.speed_right = near_limit(longint'(speed_thr));
				s.speed_left = near_limit(longint'(speed_thr));
				s.angle_fused = near_limit(longint'(tilt_lim));
				send_item(s);
			end
		end

		drain(8);
		if (mismatch_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
hdl/gdqo_pkg.sv
hdl/gdqo_lane.sv
hdl/gdqo_merge.sv
hdl/gated_dual_quadrature_odometer_unit.sv
test/tb.sv
